// ===== hdl/rucp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the replay upsample / calibrate / pack block.
// No dependencies; imported by rucp_state_mem, rucp_cal_unit and the top level.
package rucp_pkg;

    // operation codes of an input request
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // configuration register indexes
    localparam logic REG_SHORT_CODE   = 1'b0;
    localparam logic REG_PAIR_PACKING = 1'b1;

    // lane_part codes
    localparam logic [1:0] PART_WHOLE = 2'd0;
    localparam logic [1:0] PART_UPPER = 2'd1;
    localparam logic [1:0] PART_LOWER = 2'd2;

    // slot limits for the two packing modes
    localparam logic [3:0] SLOTS_SINGLE = 4'd6;
    localparam logic [3:0] SLOTS_PAIRED = 4'd12;

    // floor(0.999999 * 2^31), magnitude clamp in Q1.31
    localparam logic [30:0] CLAMP_Q31  = 31'h7FFF_F79C;
    localparam logic [30:0] FULL_SHORT = 31'h0000_7FFF;
    localparam logic [30:0] FULL_LONG  = 31'h7FFF_FFFF;

    typedef struct packed {
        logic              operation;
        logic [3:0]        channel;
        logic signed [31:0] sample;
        logic              restart;
        logic              stream_end;
        logic signed [31:0] gain;
        logic signed [31:0] offset;
        logic [31:0]       inverse_full_scale;
        logic              invert;
        logic [3:0]        output_slot;
    } in_req_t;

    typedef struct packed {
        logic [2:0]  word_lane;
        logic [1:0]  lane_part;
        logic [31:0] code_bits;
        logic        interpolated;
        logic        last;
    } out_req_t;

    // one calibration table entry
    typedef struct packed {
        logic signed [31:0] gain;
        logic signed [31:0] offset;
        logic [31:0]        scale;
        logic               invert;
        logic [3:0]         slot;
    } cal_entry_t;

    // write request into the previous-sample store
    typedef struct packed {
        logic               we;
        logic               valid;
        logic signed [31:0] sample;
    } prev_wr_t;

endpackage

// ===== hdl/rucp_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interface carrying one request payload.
// The payload type is set per instance; no other dependencies.
interface rucp_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/rucp_state_mem.sv =====
`timescale 1ns / 1ps
// Per-channel state: calibration table and previous-sample store, both
// synchronous memories with registered read. Uses rucp_pkg.
module rucp_state_mem
    import rucp_pkg::*;
#(
    parameter int CHANNELS = 12,
    parameter int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [CH_W-1:0] rd_addr,
    input  logic            cal_we,
    input  logic [CH_W-1:0] wr_addr,
    input  cal_entry_t      cal_wdata,
    input  prev_wr_t        prev_wr,
    output cal_entry_t      cal_q,
    output logic signed [31:0] prev_q,
    output logic            prev_valid_q
);

    cal_entry_t         cal_mem [CHANNELS];
    logic signed [31:0] prev_mem [CHANNELS];
    logic [CHANNELS-1:0] prev_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cal_we)
        begin
            cal_mem[wr_addr] <= cal_wdata;
        end
        if (prev_wr.we)
        begin
            prev_mem[wr_addr] <= prev_wr.sample;
        end
        cal_q  <= cal_mem[rd_addr];
        prev_q <= prev_mem[rd_addr];
    end

    // valid bits live in flops so reset clears them at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= '0;
            prev_valid_q   <= 1'b0;
        end
        else
        begin
            if (prev_wr.we)
            begin
                prev_valid_reg[wr_addr] <= prev_wr.valid;
            end
            prev_valid_q <= prev_valid_reg[rd_addr];
        end
    end

endmodule

// ===== hdl/rucp_cal_unit.sv =====
`timescale 1ns / 1ps
// Calibration datapath: gain, offset, normalize, clamp, polarity and
// converter scaling of one value over seven steps. Uses rucp_pkg.
module rucp_cal_unit
    import rucp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] value,
    input  cal_entry_t         entry,
    input  logic               short_code,
    output logic [31:0]        code,
    output logic               done
);

    logic [6:0]         step_reg;
    logic [6:0]         step_next;
    logic               done_reg;
    logic signed [31:0] v_reg;
    logic signed [63:0] prod_reg;
    logic               neg_reg;
    logic [40:0]        mag_reg;
    logic [63:0]        lo_reg;
    logic [40:0]        hi_reg;
    logic [30:0]        q_reg;
    logic [61:0]        mprod_reg;
    logic [31:0]        code_reg;

    logic signed [40:0] cal_sum;
    logic [56:0]        q_sum;
    logic [30:0]        full;
    logic [30:0]        m;

    assign step_next = {step_reg[5:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= step_reg[6];
        end
    end

    // (v*gain >> 24) + offset, floor shift
    assign cal_sum = {prod_reg[63], prod_reg[63:24]} + {{9{entry.offset[31]}}, entry.offset};
    // floor(|cal| * scale / 2^17) from the two partial products
    assign q_sum = {1'b0, hi_reg, 15'd0} + {10'd0, lo_reg[63:17]};
    assign full = short_code ? FULL_SHORT : FULL_LONG;
    assign m = mprod_reg[61:31];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= value;
        end
        if (step_reg[0])
        begin
            prod_reg <= v_reg * entry.gain;
        end
        if (step_reg[1])
        begin
            neg_reg <= cal_sum[40] ^ entry.invert;
            mag_reg <= cal_sum[40] ? 41'(41'd0 - cal_sum) : 41'(cal_sum);
        end
        if (step_reg[2])
        begin
            lo_reg <= mag_reg[31:0] * entry.scale;
        end
        if (step_reg[3])
        begin
            hi_reg <= mag_reg[40:32] * entry.scale;
        end
        if (step_reg[4])
        begin
            q_reg <= (q_sum > {26'd0, CLAMP_Q31}) ? CLAMP_Q31 : q_sum[30:0];
        end
        if (step_reg[5])
        begin
            mprod_reg <= q_reg * full;
        end
        if (step_reg[6])
        begin
            code_reg <= neg_reg ? (32'd0 - {1'b0, m}) : {1'b0, m};
        end
    end

    assign code = code_reg;
    assign done = done_reg;

endmodule

// ===== hdl/replay_upsample_calibrate_pack.sv =====
`timescale 1ns / 1ps
// Per-channel 2x linear-interpolation upsampler with calibration and packing.
// Top level; uses rucp_pkg, rucp_stream_if, rucp_state_mem and rucp_cal_unit.
//
// items (sink): one request per sample or calibration load. A load writes the
//   channel's gain, offset, reciprocal full scale, polarity and output slot.
//   A sample gives a midpoint with the channel's previous sample (unless it
//   starts a stream), then itself, then a trailing copy on stream end.
// results (source): word lane, lane part and positioned code bits; last marks
//   the final result of a request.
// cfg_we/cfg_index/cfg_data: short_code (index 0), pair_packing (index 1);
//   the user must write them only while the block is idle (not enforced).
// Sequencing: a load, or a request on a channel beyond CHANNELS, is taken in
//   the idle state. A sample reads the channel state, then calibrates and
//   emits its midpoint (if any) and itself, then a trailing copy. Each value
//   runs through the seven-step calibration unit (four multiplies) after a
//   registered memory read; the trailing copy reuses the sample's code.
// One request is worked on at a time. The result register lets the block
//   return to idle and take the next request while a result still waits; a
//   stalled receiver holds the sequencer in its emit step.
// Reset clears state, config and all previous-sample valid bits; calibration
//   entries must be loaded before samples of that channel arrive.
module replay_upsample_calibrate_pack
    import rucp_pkg::*;
#(
    parameter int CHANNELS = 12
) (
    input  logic clk,
    input  logic rst_n,
    rucp_stream_if.sink   items,
    rucp_stream_if.source results,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CALC = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        PH_MID   = 3'b001,
        PH_CUR   = 3'b010,
        PH_TRAIL = 3'b100
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   short_code_reg;
    logic   pair_packing_reg;
    in_req_t item_reg;
    logic [CH_W-1:0] item_ch_reg;
    logic    out_valid_reg, out_valid_next;
    out_req_t out_reg, out_next;

    logic            accept;
    logic            in_range;
    logic [CH_W-1:0] in_idx;
    logic [CH_W-1:0] rd_addr;
    logic [CH_W-1:0] wr_addr;
    logic            cal_we;
    cal_entry_t      cal_wdata;
    prev_wr_t        prev_wr;
    cal_entry_t      cal_q;
    logic signed [31:0] prev_q;
    logic            prev_valid_q;

    logic               cal_start;
    logic signed [31:0] cal_value;
    logic [31:0]        cal_code;
    logic               cal_done;

    logic               first;
    logic               slot_ok;
    logic signed [32:0] pair_sum;
    logic signed [31:0] mid;
    logic               out_free;
    logic               load_out;

    assign items.ready = (state_reg == S_IDLE);
    assign accept      = items.valid && items.ready;
    assign in_range    = 7'(items.payload.channel) < 7'(CHANNELS);
    assign in_idx      = CH_W'(items.payload.channel);

    assign rd_addr = (state_reg == S_IDLE && in_range) ? in_idx : item_ch_reg;
    assign wr_addr = (state_reg == S_IDLE) ? in_idx : item_ch_reg;

    assign cal_we = accept && in_range && (items.payload.operation == OP_LOAD);
    assign cal_wdata = '{
        gain:   items.payload.gain,
        offset: items.payload.offset,
        scale:  items.payload.inverse_full_scale,
        invert: items.payload.invert,
        slot:   items.payload.output_slot
    };

    rucp_state_mem #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_mem (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_addr      (rd_addr),
        .cal_we       (cal_we),
        .wr_addr      (wr_addr),
        .cal_wdata    (cal_wdata),
        .prev_wr      (prev_wr),
        .cal_q        (cal_q),
        .prev_q       (prev_q),
        .prev_valid_q (prev_valid_q)
    );

    rucp_cal_unit u_cal (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cal_start),
        .value      (cal_value),
        .entry      (cal_q),
        .short_code (short_code_reg),
        .code       (cal_code),
        .done       (cal_done)
    );

    // floor((prev + cur) / 2)
    assign pair_sum = {prev_q[31], prev_q} + {item_reg.sample[31], item_reg.sample};
    assign mid      = pair_sum[32:1];
    assign first    = item_reg.restart || !prev_valid_q;
    assign slot_ok  = pair_packing_reg ? (cal_q.slot < SLOTS_PAIRED)
                                       : (cal_q.slot < SLOTS_SINGLE);

    assign out_free = !out_valid_reg || results.ready;
    assign load_out = (state_reg == S_EMIT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cal_start  = 1'b0;
        cal_value  = item_reg.sample;
        prev_wr    = '{we: 1'b0, valid: !item_reg.stream_end, sample: item_reg.sample};
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_range && items.payload.operation == OP_SAMPLE)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                prev_wr.we = 1'b1;
                if (!slot_ok)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cal_start  = 1'b1;
                    cal_value  = first ? item_reg.sample : mid;
                    phase_next = first ? PH_CUR : PH_MID;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (cal_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    case (phase_reg)
                        PH_MID:
                        begin
                            cal_start  = 1'b1;
                            phase_next = PH_CUR;
                            state_next = S_CALC;
                        end
                        PH_CUR:
                        begin
                            if (item_reg.stream_end)
                            begin
                                phase_next = PH_TRAIL;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result formatting
    always_comb
    begin
        out_valid_next = out_valid_reg && !results.ready;
        out_next       = out_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            if (pair_packing_reg)
            begin
                out_next.word_lane = cal_q.slot[3:1];
                if (cal_q.slot[0])
                begin
                    out_next.lane_part = PART_LOWER;
                    out_next.code_bits = {16'd0, cal_code[15:0]};
                end
                else
                begin
                    out_next.lane_part = PART_UPPER;
                    out_next.code_bits = {cal_code[15:0], 16'd0};
                end
            end
            else
            begin
                out_next.word_lane = cal_q.slot[2:0];
                out_next.lane_part = PART_WHOLE;
                out_next.code_bits = cal_code;
            end
            out_next.interpolated = (phase_reg != PH_CUR);
            out_next.last = (phase_reg == PH_TRAIL)
                         || (phase_reg == PH_CUR && !item_reg.stream_end);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_CUR;
            short_code_reg   <= 1'b0;
            pair_packing_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            item_ch_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (accept && in_range)
            begin
                item_ch_reg <= in_idx;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SHORT_CODE:   short_code_reg   <= cfg_data;
                    REG_PAIR_PACKING: pair_packing_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= items.payload;
        end
        out_reg <= out_next;
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

endmodule
